FILE: src/crc32_instruction_unit_macros.svh
`ifndef CRC32_INSTRUCTION_UNIT_MACROS_SVH
`define CRC32_INSTRUCTION_UNIT_MACROS_SVH

// Implication checked on every clock edge outside of reset.
`define CRC32IU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crc32 instruction unit: implication check failed");

// Condition that must hold on every clock edge outside of reset.
`define CRC32IU_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("crc32 instruction unit: invariant check failed");

`endif

FILE: src/crc32iu_pkg.sv
package crc32iu_pkg;

  localparam int CRC_W = 32;
  localparam int DATA_W = 64;
  localparam int BYTE_W = 8;
  localparam int BYTES_MAX = DATA_W / BYTE_W;
  localparam int REMAIN_W = $clog2(BYTES_MAX + 1);
  localparam int LATENCY = BYTES_MAX + 1;

  typedef struct packed {
    logic                valid;
    logic [CRC_W-1:0]    crc;
    logic [DATA_W-1:0]   data;
    logic [CRC_W-1:0]    poly;
    logic [REMAIN_W-1:0] remain;
  } crc32iu_stage_t;

endpackage

FILE: src/crc32iu_byte_stage.sv
module crc32iu_byte_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  crc32iu_pkg::crc32iu_stage_t stage_in,
  output crc32iu_pkg::crc32iu_stage_t stage_out
);
  import crc32iu_pkg::*;

  crc32iu_stage_t stage;
  logic [CRC_W-1:0] crc_next;
  logic fb;
  logic active;

  assign active = (stage_in.remain != '0);

  // Reflected form: one data bit per step, least significant bit first.
  always_comb begin
    crc_next = stage_in.crc;
    fb = 1'b0;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = crc_next[0] ^ stage_in.data[i];
      crc_next = (crc_next >> 1) ^ ({CRC_W{fb}} & stage_in.poly);
    end
  end

  always_ff @(posedge clk) begin
    stage.poly <= stage_in.poly;
    if (active) begin
      stage.crc <= crc_next;
      stage.data <= {{BYTE_W{1'b0}}, stage_in.data[DATA_W-1:BYTE_W]};
      stage.remain <= stage_in.remain - REMAIN_W'(1);
    end else begin
      stage.crc <= stage_in.crc;
      stage.data <= stage_in.data;
      stage.remain <= stage_in.remain;
    end
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_in.valid;
    end
  end

  assign stage_out = stage;

endmodule

FILE: src/crc32_instruction_unit.sv
// CRC32 accumulate unit. A request is taken on every clock edge where start is
// high and busy is low, so one request can enter in every cycle; busy is high
// only during reset. The low 1, 2, 4 or 8 bytes of data_word, chosen by
// width_select, are folded into the accumulator one byte per pipeline stage,
// with eight byte stages behind an input register, so the result appears on
// crc_out with done high after the input register and all byte stages, whatever
// the width select. Requests leave in the order they came. The result is valid
// for a single cycle only, since the receiver cannot stall the pipeline.
module crc32_instruction_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] accumulator,
  input  logic [63:0] data_word,
  input  logic [31:0] generator,
  input  logic [1:0]  width_select,
  output logic        done,
  output logic [31:0] crc_out
);
  import crc32iu_pkg::*;

  crc32iu_stage_t head;
  crc32iu_stage_t chain [0:BYTES_MAX];
  logic [CRC_W-1:0] poly_rev;

  assign busy = rst;

  always_comb begin
    for (int i = 0; i < CRC_W; i++) begin
      poly_rev[i] = generator[CRC_W-1-i];
    end
  end

  always_ff @(posedge clk) begin
    head.crc <= accumulator;
    head.data <= data_word;
    head.poly <= poly_rev;
    head.remain <= REMAIN_W'(1) << width_select;
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= start && !busy;
    end
  end

  assign chain[0] = head;

  for (genvar g = 0; g < BYTES_MAX; g++) begin : g_stage
    crc32iu_byte_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  assign done = chain[BYTES_MAX].valid;
  assign crc_out = chain[BYTES_MAX].crc;

endmodule

FILE: src/crc32iu_checker.sv
`include "crc32_instruction_unit_macros.svh"

module crc32iu_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import crc32iu_pkg::*;

  `CRC32IU_ASSERT_ALWAYS(a_never_busy, !busy)
  `CRC32IU_ASSERT_IMP(a_request_done, start && !busy, ##LATENCY done)
  `CRC32IU_ASSERT_IMP(a_done_has_request, done, $past(start && !busy, LATENCY))
  `CRC32IU_ASSERT_IMP(a_quiet_after_reset, $past(rst), !done)

endmodule

bind crc32_instruction_unit crc32iu_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
